// ===== src/first_unique_value_tracker_core_assert.svh =====
// assertion macros for the first unique value tracker
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef FIRST_UNIQUE_VALUE_TRACKER_CORE_ASSERT_SVH
`define FIRST_UNIQUE_VALUE_TRACKER_CORE_ASSERT_SVH

// property checked at every edge outside reset
`define FUVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle implies consequence in the next
`define FUVT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/fuvt_pkg.sv =====
// shared types and constants of the first unique value tracker
// no dependencies
`default_nettype none

package fuvt_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned VALUE_W       = 32;

  typedef enum logic [1:0] {
    ST_FOUND  = 2'd0,
    ST_NONE   = 2'd1,
    ST_NOSTOP = 2'd2
  } status_e;

  // one beat walking down the cell chain
  typedef struct packed {
    logic               busy;        // slot holds a beat
    logic               live;        // beat updates the table (no stop seen yet)
    logic               last;        // final beat of the stream, clears cells behind it
    logic               stop;        // beat equals the stop value
    logic               matched;     // value already found in an earlier cell
    logic               placed;      // value written into an earlier cell
    logic               found;       // unique entry picked
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] found_value;
  } token_t;

endpackage

`default_nettype wire

// ===== src/first_unique_value_tracker_core.sv =====
// top level of the first unique value tracker, built from fuvt_cell and fuvt_pkg
// takes a stream of signed 32-bit samples and keeps the distinct values in order of first
// appearance, each entry marked once it repeats. a sample equal to the stop value (written
// through the cfg port, reset value 0) yields one result: status found with the earliest
// value seen exactly once, or status none. samples after the stop are ignored until the
// beat flagged last, which empties the table; a stream that ends without a stop yields
// status no-stop. when all TABLE_ENTRIES cells are in use, new values are dropped and the
// overflow flag of that stream's result is set. each beat walks the chain of cells, through
// the token register of every cell, and the result is registered behind the last cell;
// beats follow each other through the chain, so one beat is accepted per cycle as long as
// the output is not stalled. the whole chain holds while a result waits to be taken.
`default_nettype none

module first_unique_value_tracker_core
  import fuvt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // stop value register
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic signed [31:0]  cfg_data_i,
  // sample beats
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic signed [31:0]  sample_value_i,
  input  wire logic                last_item_i,
  // result beats
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [1:0]          status_o,
  output      logic signed [31:0]  unique_value_o,
  output      logic                overflow_o
);

  `include "first_unique_value_tracker_core_assert.svh"

  logic [VALUE_W-1:0] stop_value_q;
  logic               stop_seen_q, stop_seen_d;
  logic               ovf_seen_q, ovf_seen_d;

  logic               adv;
  logic               in_accept;
  logic               in_is_stop;

  // tok[0] enters the chain, tok[k+1] leaves cell k
  token_t             tok [TABLE_ENTRIES+1];
  token_t             tail;

  logic               emit, ovf_now, ovf_all;
  status_e            status_d;

  logic               out_valid_q;
  status_e            out_status_q;
  logic [VALUE_W-1:0] out_value_q;
  logic               out_ovf_q;

  // config port never blocks
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_value_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      stop_value_q <= cfg_data_i;
    end
  end

  // the chain and the output register move together
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_is_stop = (sample_value_i == stop_value_q);

  always_comb begin
    tok[0]             = '0;
    // after a stop only the last beat travels, and only to clear the cells
    tok[0].busy        = in_accept && (!stop_seen_q || last_item_i);
    tok[0].live        = !stop_seen_q;
    tok[0].last        = last_item_i;
    tok[0].stop        = !stop_seen_q && in_is_stop;
    tok[0].value       = sample_value_i;

    stop_seen_d = stop_seen_q;
    if (in_accept) begin
      stop_seen_d = last_item_i ? 1'b0 : (stop_seen_q | in_is_stop);
    end
  end

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    fuvt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .tok_i (tok[k]),
      .tok_o (tok[k+1])
    );
  end

  assign tail = tok[TABLE_ENTRIES];

  // tail of the chain: form the result and track overflow per stream
  always_comb begin
    emit    = tail.busy && tail.live && (tail.stop || tail.last);
    ovf_now = tail.busy && tail.live && !tail.matched && !tail.placed;
    ovf_all = ovf_seen_q | ovf_now;

    ovf_seen_d = ovf_seen_q;
    if (tail.busy) begin
      ovf_seen_d = tail.last ? 1'b0 : ovf_all;
    end

    if (!tail.stop) begin
      status_d = ST_NOSTOP;
    end else if (tail.found) begin
      status_d = ST_FOUND;
    end else begin
      status_d = ST_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_seen_q <= 1'b0;
      ovf_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      stop_seen_q <= stop_seen_d;
      ovf_seen_q  <= ovf_seen_d;
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_status_q <= status_d;
      out_value_q  <= (status_d == ST_FOUND) ? tail.found_value : '0;
      out_ovf_q    <= ovf_all;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign unique_value_o = out_value_q;
  assign overflow_o     = out_ovf_q;

  // a result without a unique value carries zero
  `FUVT_ASSERT(a_value_zero, out_valid_q && (out_status_q != ST_FOUND) |-> (out_value_q == '0), "unique value set without found status")

  // the last beat always ends the stop phase
  `FUVT_ASSERT_NEXT(a_last_clears_stop, in_accept && last_item_i, !stop_seen_q, "stop flag survived last beat")

  // the stop phase starts only from an accepted stop beat
  `FUVT_ASSERT(a_stop_origin, $rose(stop_seen_q) |-> $past(in_accept && in_is_stop && !last_item_i), "stop flag set without stop beat")

  // a result only leaves the chain on a live stop or last beat
  `FUVT_ASSERT_NEXT(a_emit_source, adv && tail.busy && !tail.live, !out_valid_q, "result from an ignored beat")

endmodule

`default_nettype wire

// ===== src/fuvt_cell.sv =====
// one table entry of the tracker plus the token stage that follows it
// depends on fuvt_pkg
`default_nettype none

module fuvt_cell
  import fuvt_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   adv_i,
  input  wire token_t tok_i,
  output token_t      tok_o
);

  logic               valid_q, valid_d;
  logic               rep_q, rep_d;
  logic [VALUE_W-1:0] value_q, value_d;
  token_t             tok_q, tok_d;

  logic hit, place, new_valid, new_rep;

  always_comb begin
    hit       = tok_i.busy && tok_i.live && valid_q && (value_q == tok_i.value);
    place     = tok_i.busy && tok_i.live && !valid_q && !tok_i.matched && !tok_i.placed;
    new_valid = valid_q | place;
    new_rep   = place ? 1'b0 : (rep_q | hit);
    value_d   = place ? tok_i.value : value_q;

    tok_d         = tok_i;
    tok_d.matched = tok_i.matched | hit;
    tok_d.placed  = tok_i.placed | place;
    if (tok_i.busy && tok_i.stop && !tok_i.found && new_valid && !new_rep) begin
      tok_d.found       = 1'b1;
      tok_d.found_value = value_d;
    end

    // the last beat empties each cell as it passes
    if (tok_i.busy && tok_i.last) begin
      valid_d = 1'b0;
      rep_d   = 1'b0;
    end else begin
      valid_d = new_valid;
      rep_d   = new_rep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rep_q   <= 1'b0;
      tok_q   <= '0;
    end else if (adv_i) begin
      valid_q <= valid_d;
      rep_q   <= rep_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      value_q <= value_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire
